FILE: design/ume_pkg.sv
// ----------------------------------------------------------------------------
// ume_pkg
// Shared types and constants for the UM-32 execute core.
// ----------------------------------------------------------------------------
package ume_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned RegCount  = 8;
    localparam int unsigned RegIdxW   = 3;
    localparam int unsigned ImmWidth  = 25;
    localparam int unsigned DivSteps  = 32;

    typedef enum logic [3:0] {
        OPC_CMOV  = 4'd0,
        OPC_LOAD  = 4'd1,
        OPC_STORE = 4'd2,
        OPC_ADD   = 4'd3,
        OPC_MUL   = 4'd4,
        OPC_DIV   = 4'd5,
        OPC_NAND  = 4'd6,
        OPC_HALT  = 4'd7,
        OPC_MAP   = 4'd8,
        OPC_UNMAP = 4'd9,
        OPC_OUT   = 4'd10,
        OPC_IN    = 4'd11,
        OPC_LDPRG = 4'd12,
        OPC_LDIMM = 4'd13
    } opcode_t;

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_LOAD    = 4'd1,
        ACT_STORE   = 4'd2,
        ACT_MAP     = 4'd3,
        ACT_UNMAP   = 4'd4,
        ACT_OUTPUT  = 4'd5,
        ACT_INPUT   = 4'd6,
        ACT_LOADPRG = 4'd7,
        ACT_HALT    = 4'd8,
        ACT_FAULT   = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       operation;
        logic [31:0] word;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] arg_first;
        logic [31:0] arg_second;
        logic [31:0] arg_third;
        logic [31:0] next_pc;
    } out_beat_t;

endpackage

FILE: design/ume_stream_if.sv
// ----------------------------------------------------------------------------
// ume_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ume_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/universal_machine_execute.sv
// ----------------------------------------------------------------------------
// universal_machine_execute
// UM-32 execute core: registers, pc, decode, request issue.
// ----------------------------------------------------------------------------
// Each beat is accepted, then its result is written to the output register,
// except a divide with a nonzero divisor, which first runs a one-bit-per-cycle
// restoring divider. The next beat is accepted once the result has been
// taken. Multiply is a single 32x32 low-half product.
module universal_machine_execute (
    input  logic clk,
    input  logic rst_n,
    ume_stream_if.sink   in_ch,
    ume_stream_if.source out_ch
);

    ume_pkg::state_t  state_reg, state_next;
    logic [31:0] regs_reg [ume_pkg::RegCount];
    logic [31:0] pc_reg;
    logic        wait_reg;
    logic [2:0]  wreg_reg;
    ume_pkg::out_beat_t res_reg;

    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  dst_reg;

    ume_pkg::in_beat_t ib;
    logic [3:0]  opc;
    logic [2:0]  ra, rb, rc;
    logic [31:0] va, vb, vc, npc;
    logic [32:0] trial;
    logic        accept;

    assign ib     = in_ch.data;
    assign accept = in_ch.valid && in_ch.ready;
    assign opc    = ib.word[31:28];
    assign ra     = ib.word[8:6];
    assign rb     = ib.word[5:3];
    assign rc     = ib.word[2:0];
    assign va     = regs_reg[ra];
    assign vb     = regs_reg[rb];
    assign vc     = regs_reg[rc];
    assign npc    = pc_reg + 32'd1;
    assign trial  = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ume_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!ib.operation && !wait_reg &&
                        opc == ume_pkg::OPC_DIV && vc != 32'd0)
                        state_next = ume_pkg::ST_DIV;
                    else
                        state_next = ume_pkg::ST_OUT;
                end
            end
            ume_pkg::ST_DIV:
                if (cnt_reg == 6'(ume_pkg::DivSteps - 1))
                    state_next = ume_pkg::ST_OUT;
            ume_pkg::ST_OUT:
                if (out_ch.ready)
                    state_next = ume_pkg::ST_IDLE;
            default:
                state_next = ume_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready  = (state_reg == ume_pkg::ST_IDLE);
        out_ch.valid = (state_reg == ume_pkg::ST_OUT);
        out_ch.data  = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ume_pkg::ST_IDLE;
            pc_reg    <= '0;
            wait_reg  <= 1'b0;
            wreg_reg  <= '0;
            cnt_reg   <= '0;
            res_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            dst_reg   <= '0;
            for (int i = 0; i < ume_pkg::RegCount; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ume_pkg::ST_DIV)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (!trial[32])
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                if (cnt_reg == 6'(ume_pkg::DivSteps - 1))
                begin
                    regs_reg[dst_reg] <= trial[32] ? {quo_reg[30:0], 1'b0}
                                                   : {quo_reg[30:0], 1'b1};
                    pc_reg <= npc;
                    res_reg <= '{ume_pkg::ACT_NONE, 32'd0, 32'd0, 32'd0, npc};
                end
            end
            else if (accept)
            begin
                if (ib.operation)
                begin
                    if (wait_reg)
                    begin
                        regs_reg[wreg_reg] <= ib.word;
                        wait_reg <= 1'b0;
                        res_reg <= '{ume_pkg::ACT_NONE, 32'd0, 32'd0, 32'd0, pc_reg};
                    end
                    else
                        res_reg <= '{ume_pkg::ACT_FAULT, 32'd0, 32'd0, 32'd0, pc_reg};
                end
                else if (wait_reg)
                    res_reg <= '{ume_pkg::ACT_FAULT, 32'd0, 32'd0, 32'd0, pc_reg};
                else
                begin
                    case (opc)
                        ume_pkg::OPC_LDIMM:
                        begin
                            regs_reg[ib.word[27:25]] <= 32'(ib.word[24:0]);
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_NONE, 32'd0, 32'd0, 32'd0, npc};
                        end
                        ume_pkg::OPC_DIV:
                        begin
                            if (vc != 32'd0)
                            begin
                                quo_reg <= vb;
                                rem_reg <= '0;
                                dvs_reg <= vc;
                                dst_reg <= ra;
                                cnt_reg <= '0;
                            end
                            else
                                res_reg <= '{ume_pkg::ACT_FAULT, 32'd0, 32'd0, 32'd0,
                                             pc_reg};
                        end
                        ume_pkg::OPC_HALT:
                            res_reg <= '{ume_pkg::ACT_HALT, 32'd0, 32'd0, 32'd0, pc_reg};
                        ume_pkg::OPC_CMOV, ume_pkg::OPC_ADD, ume_pkg::OPC_MUL,
                        ume_pkg::OPC_NAND:
                        begin
                            case (opc)
                                ume_pkg::OPC_CMOV:
                                    if (vc != 32'd0)
                                        regs_reg[ra] <= vb;
                                ume_pkg::OPC_ADD: regs_reg[ra] <= vb + vc;
                                ume_pkg::OPC_MUL: regs_reg[ra] <= vb * vc;
                                default:          regs_reg[ra] <= ~(vb & vc);
                            endcase
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_NONE, 32'd0, 32'd0, 32'd0, npc};
                        end
                        ume_pkg::OPC_LOAD:
                        begin
                            wait_reg <= 1'b1;
                            wreg_reg <= ra;
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_LOAD, vb, vc, 32'd0, npc};
                        end
                        ume_pkg::OPC_STORE:
                        begin
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_STORE, va, vb, vc, npc};
                        end
                        ume_pkg::OPC_MAP:
                        begin
                            wait_reg <= 1'b1;
                            wreg_reg <= rb;
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_MAP, vc, 32'd0, 32'd0, npc};
                        end
                        ume_pkg::OPC_UNMAP:
                        begin
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_UNMAP, vc, 32'd0, 32'd0, npc};
                        end
                        ume_pkg::OPC_OUT:
                        begin
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_OUTPUT, vc, 32'd0, 32'd0, npc};
                        end
                        ume_pkg::OPC_IN:
                        begin
                            wait_reg <= 1'b1;
                            wreg_reg <= rc;
                            pc_reg <= npc;
                            res_reg <= '{ume_pkg::ACT_INPUT, 32'd0, 32'd0, 32'd0, npc};
                        end
                        ume_pkg::OPC_LDPRG:
                        begin
                            pc_reg <= vc;
                            res_reg <= '{ume_pkg::ACT_LOADPRG, vb, 32'd0, 32'd0, vc};
                        end
                        default:
                            res_reg <= '{ume_pkg::ACT_FAULT, 32'd0, 32'd0, 32'd0, pc_reg};
                    endcase
                end
            end
        end
    end

endmodule
